// ===== hdl/sdi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdi_pkg
// types, phase codes and command tables for the sd spi init sequencer
// ----------------------------------------------------------------------------
package sdi_pkg;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       select_gap;
        logic       finished;
        logic [2:0] status;
        logic       high_capacity;
    } t_out;

    localparam logic [3:0] PH_CMD0   = 4'd0;
    localparam logic [3:0] PH_IFC    = 4'd1;
    localparam logic [3:0] PH_OCR1   = 4'd2;
    localparam logic [3:0] PH_APP    = 4'd3;
    localparam logic [3:0] PH_OPC    = 4'd4;
    localparam logic [3:0] PH_OCR2   = 4'd5;
    localparam logic [3:0] PH_CRCOFF = 4'd6;
    localparam logic [3:0] PH_BLEN   = 4'd7;
    localparam logic [3:0] PH_DONE   = 4'd8;
    localparam logic [3:0] PH_IDLE   = 4'd9;

    localparam logic [2:0] ST_PRE   = 3'd0;
    localparam logic [2:0] ST_FRAME = 3'd1;
    localparam logic [2:0] ST_POLL  = 3'd2;
    localparam logic [2:0] ST_TAIL  = 3'd3;
    localparam logic [2:0] ST_POST  = 3'd4;

    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_IDLE_ERR = 3'd1;
    localparam logic [2:0] STS_OLD      = 3'd2;
    localparam logic [2:0] STS_VOLT     = 3'd3;
    localparam logic [2:0] STS_STUCK    = 3'd4;

    localparam logic [7:0] CMD_TIMEOUT_RST = 8'd100;
    localparam logic [9:0] POST_LEN        = 10'd500;
    localparam logic [7:0] CMD0_MAX        = 8'd254;

    function automatic logic [7:0] cmd_no(input logic [2:0] p);
        case (p)
            3'd1:    cmd_no = 8'd8;
            3'd2:    cmd_no = 8'd58;
            3'd3:    cmd_no = 8'd55;
            3'd4:    cmd_no = 8'd41;
            3'd5:    cmd_no = 8'd58;
            3'd6:    cmd_no = 8'd59;
            3'd7:    cmd_no = 8'd16;
            default: cmd_no = 8'd0;
        endcase
    endfunction

    function automatic logic [31:0] cmd_arg(input logic [2:0] p);
        case (p)
            3'd1:    cmd_arg = 32'h0000_01AA;
            3'd4:    cmd_arg = 32'h4000_0000;
            3'd7:    cmd_arg = 32'd512;
            default: cmd_arg = 32'd0;
        endcase
    endfunction

    function automatic logic [7:0] cmd_crc(input logic [2:0] p);
        case (p)
            3'd1:    cmd_crc = 8'h87;
            3'd4:    cmd_crc = 8'h3B;
            default: cmd_crc = 8'h95;
        endcase
    endfunction

    function automatic logic [2:0] pre_len(input logic [2:0] p);
        pre_len = (p == 3'd2) ? 3'd2 : 3'd4;
    endfunction

    function automatic logic has_tail(input logic [2:0] p);
        has_tail = (p == 3'd1) || (p == 3'd2) || (p == 3'd5);
    endfunction

    function automatic logic opens_gap(input logic [2:0] p);
        opens_gap = !((p == 3'd4) || (p == 3'd7));
    endfunction

    // byte i of the six-byte command frame
    function automatic logic [7:0] frame_byte(input logic [2:0] p, input logic [2:0] i);
        logic [31:0] a;
        a = cmd_arg(p);
        case (i)
            3'd0:    frame_byte = 8'h40 | (cmd_no(p) & 8'h3F);
            3'd1:    frame_byte = a[31:24];
            3'd2:    frame_byte = a[23:16];
            3'd3:    frame_byte = a[15:8];
            3'd4:    frame_byte = a[7:0];
            default: frame_byte = cmd_crc(p);
        endcase
    endfunction

endpackage

// ===== hdl/sd_spi_init_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sd_spi_init_sequencer
// sd card spi-mode bring-up sequencer, one byte exchange per beat
// ----------------------------------------------------------------------------
// usage:
//   input beat: mode 0 starts (or restarts) the bring-up, mode 1 reports one
//   finished spi byte exchange with the byte the card returned.
//   output beat: one per input beat, the next byte to shift, whether chip
//   select must be pulsed high first, and once done the finished flag,
//   status code and high capacity flag.
//   config channel: valid/ready write of cmd_timeout, always ready; write it
//   only while the block is idle.
// result: each accepted input beat's result is registered (skid if held).
// throughput: one beat per cycle while o_stall is low; the sequencer step is
//   a single pass of logic from the state registers, so the spi shifter sets
//   the real rate.
// reset: cmd_timeout returns to 100, sequencer idles (tx 0xff), no output.
// stall: results wait in an output register plus one skid entry; input stall
//   rises when the skid holds a beat.
// ----------------------------------------------------------------------------
module sd_spi_init_sequencer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  sdi_pkg::t_in  i_data,
    output logic          o_stall,
    output logic          o_valid,
    output sdi_pkg::t_out o_data,
    input  logic          i_stall,
    input  logic          i_cfg_valid,
    input  logic [7:0]    i_cfg_data,
    output logic          o_cfg_ready
);
    logic [7:0] r_timeout;
    logic [3:0] r_phase, n_phase;
    logic [2:0] r_stage, n_stage;
    logic [9:0] r_cnt, n_cnt;
    logic [7:0] r_retry, n_retry;
    logic [8:0] r_poll, n_poll;
    logic [7:0] r_resp [5];
    logic [7:0] n_resp [5];
    logic       r_cap, n_cap;
    logic [2:0] r_code, n_code;

    logic          w_ready, w_take;
    sdi_pkg::t_out w_out;

    assign o_stall     = !w_ready;
    assign o_cfg_ready = 1'b1;
    assign w_take      = i_valid && w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_timeout <= sdi_pkg::CMD_TIMEOUT_RST;
        else if (i_cfg_valid) r_timeout <= i_cfg_data;
    end

    // one sequencer step
    always_comb begin
        logic [2:0] p;
        logic       ends, done;
        n_phase = r_phase; n_stage = r_stage; n_cnt = r_cnt; n_retry = r_retry;
        n_poll  = r_poll;  n_cap   = r_cap;   n_code = r_code;
        for (int k = 0; k < 5; k++) n_resp[k] = r_resp[k];
        p    = r_phase[2:0];
        ends = 1'b0;
        done = 1'b0;
        if (!i_data.mode) begin
            n_retry = '0; n_poll = '0; n_cap = 1'b0; n_code = sdi_pkg::STS_OK;
            for (int k = 0; k < 5; k++) n_resp[k] = '0;
            n_phase = sdi_pkg::PH_CMD0; n_stage = sdi_pkg::ST_PRE; n_cnt = '0;
        end else if (r_phase < sdi_pkg::PH_DONE) begin
            case (r_stage)
                sdi_pkg::ST_PRE: begin
                    n_cnt = r_cnt + 10'd1;
                    if (n_cnt >= {7'd0, sdi_pkg::pre_len(p)}) begin
                        n_stage = sdi_pkg::ST_FRAME; n_cnt = '0;
                    end
                end
                sdi_pkg::ST_FRAME: begin
                    n_cnt = r_cnt + 10'd1;
                    if (n_cnt >= 10'd6) begin
                        n_stage = sdi_pkg::ST_POLL; n_poll = '0;
                    end
                end
                sdi_pkg::ST_POLL: begin
                    ends   = !i_data.rx_byte[7] || (r_poll > {1'b0, r_timeout});
                    n_poll = r_poll + 9'd1;
                    if (ends) begin
                        n_resp[0] = i_data.rx_byte;
                        n_cnt     = '0;
                        if (sdi_pkg::has_tail(p)) n_stage = sdi_pkg::ST_TAIL;
                        else if (r_phase == sdi_pkg::PH_OPC) n_stage = sdi_pkg::ST_POST;
                        else done = 1'b1;
                    end
                end
                sdi_pkg::ST_TAIL: begin
                    case (r_cnt)
                        10'd0:   n_resp[1] = i_data.rx_byte;
                        10'd1:   n_resp[2] = i_data.rx_byte;
                        10'd2:   n_resp[3] = i_data.rx_byte;
                        10'd3:   n_resp[4] = i_data.rx_byte;
                        default: ;
                    endcase
                    n_cnt = r_cnt + 10'd1;
                    if (n_cnt >= 10'd5) done = 1'b1;
                end
                default: begin
                    n_cnt = r_cnt + 10'd1;
                    if (n_cnt >= sdi_pkg::POST_LEN) done = 1'b1;
                end
            endcase
            if (done) begin
                n_stage = sdi_pkg::ST_PRE;
                n_cnt   = '0;
                case (r_phase)
                    sdi_pkg::PH_CMD0: begin
                        n_retry = r_retry + 8'd1;
                        if (r_retry >= sdi_pkg::CMD0_MAX) begin
                            n_phase = sdi_pkg::PH_DONE; n_code = sdi_pkg::STS_IDLE_ERR;
                        end else if (n_resp[0] == 8'h01) n_phase = sdi_pkg::PH_IFC;
                    end
                    sdi_pkg::PH_IFC: begin
                        if (n_resp[0][2]) begin
                            n_phase = sdi_pkg::PH_DONE; n_code = sdi_pkg::STS_OLD;
                        end else if (n_resp[1] != 8'h00 || n_resp[2] != 8'h00 ||
                                     n_resp[3] != 8'h01 || n_resp[4] != 8'hAA) begin
                            n_phase = sdi_pkg::PH_DONE; n_code = sdi_pkg::STS_VOLT;
                        end else n_phase = sdi_pkg::PH_OCR1;
                    end
                    sdi_pkg::PH_OCR1: begin
                        if ((n_resp[2] & 8'h38) != 8'h38) begin
                            n_phase = sdi_pkg::PH_DONE; n_code = sdi_pkg::STS_VOLT;
                        end else begin
                            n_retry = 8'd1; n_phase = sdi_pkg::PH_APP;
                        end
                    end
                    sdi_pkg::PH_APP: n_phase = sdi_pkg::PH_OPC;
                    sdi_pkg::PH_OPC: begin
                        if (n_resp[0] != 8'h00 && r_retry < r_timeout) begin
                            n_retry = r_retry + 8'd1; n_phase = sdi_pkg::PH_APP;
                        end else if (r_retry >= r_timeout) begin
                            n_phase = sdi_pkg::PH_DONE; n_code = sdi_pkg::STS_STUCK;
                        end else n_phase = sdi_pkg::PH_OCR2;
                    end
                    sdi_pkg::PH_OCR2: begin
                        n_cap = n_resp[1][6]; n_phase = sdi_pkg::PH_CRCOFF;
                    end
                    sdi_pkg::PH_CRCOFF: n_phase = sdi_pkg::PH_BLEN;
                    default: begin
                        n_phase = sdi_pkg::PH_DONE; n_code = sdi_pkg::STS_OK;
                    end
                endcase
            end
        end
    end

    // result from the next state
    always_comb begin
        w_out = '0;
        w_out.high_capacity = n_cap;
        if (n_phase < sdi_pkg::PH_DONE) begin
            w_out.tx_byte = (n_stage == sdi_pkg::ST_FRAME) ?
                sdi_pkg::frame_byte(n_phase[2:0], n_cnt[2:0]) : 8'hFF;
            w_out.select_gap = (n_stage == sdi_pkg::ST_PRE) && (n_cnt == '0) &&
                sdi_pkg::opens_gap(n_phase[2:0]);
        end else if (n_phase == sdi_pkg::PH_DONE) begin
            w_out.finished = 1'b1;
            w_out.status   = n_code;
        end else begin
            w_out.tx_byte       = 8'hFF;
            w_out.high_capacity = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sdi_pkg::PH_IDLE;
            r_stage <= sdi_pkg::ST_PRE;
            r_cnt   <= '0;
            r_retry <= '0;
            r_poll  <= '0;
            r_cap   <= 1'b0;
            r_code  <= sdi_pkg::STS_OK;
        end else if (w_take) begin
            r_phase <= n_phase;
            r_stage <= n_stage;
            r_cnt   <= n_cnt;
            r_retry <= n_retry;
            r_poll  <= n_poll;
            r_cap   <= n_cap;
            r_code  <= n_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            for (int k = 0; k < 5; k++) r_resp[k] <= n_resp[k];
        end
    end

    sdi_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_take),
        .i_data  (w_out),
        .o_ready (w_ready),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take && !i_data.mode |=> r_phase == sdi_pkg::PH_CMD0)
        else $error("start did not enter cmd0");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == sdi_pkg::PH_DONE && w_take && i_data.mode |=> r_phase == sdi_pkg::PH_DONE)
        else $error("left done without start");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stage == sdi_pkg::ST_FRAME |-> r_cnt < 10'd6)
        else $error("frame index out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_code <= sdi_pkg::STS_STUCK)
        else $error("bad status code");
endmodule

// ===== hdl/sdi_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdi_out_reg
// output register with skid stage, full rate while the receiver takes results
// ----------------------------------------------------------------------------
module sdi_out_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  sdi_pkg::t_out  i_data,
    output logic           o_ready,
    output logic           o_valid,
    output sdi_pkg::t_out  o_data,
    input  logic           i_stall
);
    logic          r_valid, r_skid_valid;
    sdi_pkg::t_out r_data, r_skid;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_valid || !i_stall) begin
                if (r_skid_valid) begin
                    r_valid      <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_valid <= i_valid;
                end
            end else if (i_valid && !r_skid_valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_valid || !i_stall) begin
            r_data <= r_skid_valid ? r_skid : i_data;
        end
        if (r_valid && i_stall && i_valid && !r_skid_valid) begin
            r_skid <= i_data;
        end
    end

    // skid only fills while output is held
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_valid && i_stall))
        else $error("skid filled without stall");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_valid)
        else $error("skid full with empty output");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_stall |=> r_valid)
        else $error("held result dropped");
endmodule

// ===== verif/tb_sd_spi_init_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sd_spi_init_sequencer
// self-checking bench for the sd spi bring-up sequencer: a directed table
// walks the first command frame, then simulated cards of several kinds
// (good, old, bad echo, bad voltage, stuck in idle, silent, noisy, and one
// good card that leaves idle on its first acmd41) are run through the
// sequence under several timeout settings and idle patterns, every output
// beat checked against the directed table or a local model of the sequencer
// ----------------------------------------------------------------------------
module tb_sd_spi_init_sequencer;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_BEATS    = 50;
    localparam int HOLD_CYCLES    = 60;

    typedef enum int {
        CARD_GOOD, CARD_OLD, CARD_ECHO, CARD_VOLT, CARD_STUCK,
        CARD_NOISE, CARD_SILENT, CARD_FAST
    } t_card;

    typedef struct {
        logic          mode;
        logic [7:0]    rx;
        bit            typed;
        sdi_pkg::t_out want;
    } t_dir_row;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    sdi_pkg::t_in  i_data;
    logic          o_stall;
    logic          o_valid;
    sdi_pkg::t_out o_data;
    logic          i_stall = 1'b0;
    logic          i_cfg_valid;
    logic  [7:0]   i_cfg_data;
    logic          o_cfg_ready;

    sd_spi_init_sequencer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_data      (o_data),
        .i_stall     (i_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    // local copy of the sequencer state
    logic [3:0] seq_phase;
    logic [2:0] seq_stage;
    int         seq_cnt;
    logic [7:0] seq_retry;
    int         seq_poll;
    logic [7:0] seq_resp [5];
    logic       seq_cap;
    logic [2:0] seq_code;
    logic [7:0] seq_tmo;

    sdi_pkg::t_out tx_expect_q [$];
    int   errors = 0;
    int   beats_sent;
    int   idle_pct;
    int   stall_pct;
    int   hold_req;
    int   hold_seen = 0;
    int   hold_left = 0;
    int   quiet_cycles = 0;
    bit   run_active;

    // ---------------------------------------------------------------- model

    function automatic logic [7:0] frame_of(logic [3:0] ph, int idx);
        logic [7:0]  cmd;
        logic [31:0] arg;
        logic [7:0]  crc;
        cmd = 8'd0;
        arg = 32'd0;
        crc = 8'h95;
        case (ph)
            sdi_pkg::PH_IFC: begin
                cmd = 8'd8;
                arg = 32'h0000_01AA;
                crc = 8'h87;
            end
            sdi_pkg::PH_OCR1, sdi_pkg::PH_OCR2: cmd = 8'd58;
            sdi_pkg::PH_APP: cmd = 8'd55;
            sdi_pkg::PH_OPC: begin
                cmd = 8'd41;
                arg = 32'h4000_0000;
                crc = 8'h3B;
            end
            sdi_pkg::PH_CRCOFF: cmd = 8'd59;
            sdi_pkg::PH_BLEN: begin
                cmd = 8'd16;
                arg = 32'd512;
            end
            default: cmd = 8'd0;
        endcase
        if (idx == 0) return 8'h40 | (cmd & 8'h3F);
        if (idx <= 4) return 8'(arg >> (8 * (4 - idx)));
        return crc;
    endfunction

    function automatic void open_cmd(logic [3:0] ph);
        seq_phase = ph;
        seq_stage = sdi_pkg::ST_PRE;
        seq_cnt   = 0;
    endfunction

    function automatic void close_seq(logic [2:0] code);
        seq_phase = sdi_pkg::PH_DONE;
        seq_code  = code;
    endfunction

    // decision taken once a command's response is complete
    function automatic void finish_cmd();
        case (seq_phase)
            sdi_pkg::PH_CMD0: begin
                seq_retry = seq_retry + 8'd1;
                if (seq_retry > 8'd254) close_seq(sdi_pkg::STS_IDLE_ERR);
                else if (seq_resp[0] == 8'h01) open_cmd(sdi_pkg::PH_IFC);
                else open_cmd(sdi_pkg::PH_CMD0);
            end
            sdi_pkg::PH_IFC: begin
                if (seq_resp[0][2]) close_seq(sdi_pkg::STS_OLD);
                else if (seq_resp[1] != 8'h00 || seq_resp[2] != 8'h00 ||
                         seq_resp[3] != 8'h01 || seq_resp[4] != 8'hAA)
                    close_seq(sdi_pkg::STS_VOLT);
                else open_cmd(sdi_pkg::PH_OCR1);
            end
            sdi_pkg::PH_OCR1: begin
                if ((seq_resp[2] & 8'h38) != 8'h38) begin
                    close_seq(sdi_pkg::STS_VOLT);
                end else begin
                    seq_retry = 8'd1;
                    open_cmd(sdi_pkg::PH_APP);
                end
            end
            sdi_pkg::PH_APP: open_cmd(sdi_pkg::PH_OPC);
            sdi_pkg::PH_OPC: begin
                if (seq_resp[0] != 8'h00 && seq_retry < seq_tmo) begin
                    seq_retry = seq_retry + 8'd1;
                    open_cmd(sdi_pkg::PH_APP);
                end else if (seq_retry >= seq_tmo) begin
                    close_seq(sdi_pkg::STS_STUCK);
                end else begin
                    open_cmd(sdi_pkg::PH_OCR2);
                end
            end
            sdi_pkg::PH_OCR2: begin
                seq_cap = seq_resp[1][6];
                open_cmd(sdi_pkg::PH_CRCOFF);
            end
            sdi_pkg::PH_CRCOFF: open_cmd(sdi_pkg::PH_BLEN);
            default: close_seq(sdi_pkg::STS_OK);
        endcase
    endfunction

    function automatic void advance_byte(logic [7:0] rx);
        bit ends;
        bit has_tail;
        has_tail = (seq_phase == sdi_pkg::PH_IFC) || (seq_phase == sdi_pkg::PH_OCR1) ||
                   (seq_phase == sdi_pkg::PH_OCR2);
        case (seq_stage)
            sdi_pkg::ST_PRE: begin
                seq_cnt++;
                if (seq_cnt >= ((seq_phase == sdi_pkg::PH_OCR1) ? 2 : 4)) begin
                    seq_stage = sdi_pkg::ST_FRAME;
                    seq_cnt   = 0;
                end
            end
            sdi_pkg::ST_FRAME: begin
                seq_cnt++;
                if (seq_cnt >= 6) begin
                    seq_stage = sdi_pkg::ST_POLL;
                    seq_poll  = 0;
                end
            end
            sdi_pkg::ST_POLL: begin
                // last polled byte counts as r1 on timeout
                ends = !rx[7] || (seq_poll > seq_tmo);
                seq_poll++;
                if (ends) begin
                    seq_resp[0] = rx;
                    seq_cnt     = 0;
                    if (has_tail) seq_stage = sdi_pkg::ST_TAIL;
                    else if (seq_phase == sdi_pkg::PH_OPC) seq_stage = sdi_pkg::ST_POST;
                    else finish_cmd();
                end
            end
            sdi_pkg::ST_TAIL: begin
                if (seq_cnt < 4) seq_resp[seq_cnt + 1] = rx;
                seq_cnt++;
                if (seq_cnt >= 5) finish_cmd();
            end
            default: begin
                seq_cnt++;
                if (seq_cnt >= sdi_pkg::POST_LEN) finish_cmd();
            end
        endcase
    endfunction

    function automatic sdi_pkg::t_out sequencer_step(sdi_pkg::t_in it);
        sdi_pkg::t_out r;
        if (!it.mode) begin
            seq_retry = 8'd0;
            seq_poll  = 0;
            seq_cap   = 1'b0;
            seq_code  = sdi_pkg::STS_OK;
            foreach (seq_resp[k]) seq_resp[k] = 8'h00;
            open_cmd(sdi_pkg::PH_CMD0);
        end else if (seq_phase < sdi_pkg::PH_DONE) begin
            advance_byte(it.rx_byte);
        end
        r = '0;
        r.high_capacity = seq_cap;
        if (seq_phase < sdi_pkg::PH_DONE) begin
            r.tx_byte    = (seq_stage == sdi_pkg::ST_FRAME) ?
                           frame_of(seq_phase, seq_cnt) : 8'hFF;
            r.select_gap = (seq_stage == sdi_pkg::ST_PRE) && (seq_cnt == 0) &&
                           (seq_phase != sdi_pkg::PH_OPC) && (seq_phase != sdi_pkg::PH_BLEN);
        end else if (seq_phase == sdi_pkg::PH_DONE) begin
            r.finished = 1'b1;
            r.status   = seq_code;
        end else begin
            r.tx_byte       = 8'hFF;
            r.high_capacity = 1'b0;
        end
        return r;
    endfunction

    // what a card of the given kind would return for the byte now on the wire
    function automatic logic [7:0] card_reply(t_card c);
        logic [7:0] rnd;
        rnd = 8'($urandom);
        if (c == CARD_NOISE) return rnd;
        if (seq_stage == sdi_pkg::ST_POLL) begin
            if (c == CARD_SILENT || $urandom_range(99) < 20) return rnd | 8'h80;
            case (seq_phase)
                sdi_pkg::PH_CMD0: return 8'h01;
                sdi_pkg::PH_IFC:  return (c == CARD_OLD) ? 8'h05 : 8'h01;
                sdi_pkg::PH_OCR1, sdi_pkg::PH_APP, sdi_pkg::PH_OCR2: return 8'h01;
                sdi_pkg::PH_OPC:
                    return (c == CARD_STUCK || (c != CARD_FAST && $urandom_range(1))) ?
                           8'h01 : 8'h00;
                default: return 8'h00;
            endcase
        end
        if (seq_stage == sdi_pkg::ST_TAIL && seq_phase == sdi_pkg::PH_IFC && c != CARD_ECHO) begin
            case (seq_cnt)
                0:       return 8'h00;
                1:       return 8'h00;
                2:       return 8'h01;
                3:       return 8'hAA;
                default: return rnd;
            endcase
        end
        if (seq_stage == sdi_pkg::ST_TAIL && seq_phase == sdi_pkg::PH_OCR1 && seq_cnt == 1) begin
            // voltage window bits 19..21 sit in this byte
            if (c == CARD_VOLT) return rnd & ~(8'h08 << $urandom_range(2));
            return rnd | 8'h38;
        end
        return rnd;
    endfunction

    // ---------------------------------------------------------------- clock

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- driving

    // offer one beat; valid stays high into the next beat unless idling
    task automatic send_beat(sdi_pkg::t_in it, bit typed, sdi_pkg::t_out want);
        sdi_pkg::t_out predicted;
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predicted = sequencer_step(it);
        tx_expect_q.push_back(typed ? want : predicted);
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_byte(logic mode, logic [7:0] rx);
        sdi_pkg::t_in it;
        it.mode    = mode;
        it.rx_byte = rx;
        send_beat(it, 1'b0, '0);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (tx_expect_q.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_timeout(logic [7:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        seq_tmo = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // one bring-up against one card, a few ignored beats after the end
    task automatic run_card(t_card c, int cap);
        int n;
        send_byte(1'b0, 8'($urandom));
        for (n = 0; n < cap; n++) begin
            if (seq_phase == sdi_pkg::PH_DONE) begin
                repeat ($urandom_range(3)) send_byte(1'b1, 8'($urandom));
                return;
            end
            if ($urandom_range(999) < 2) send_byte(1'b0, 8'($urandom));
            else send_byte(1'b1, card_reply(c));
        end
    endtask

    // ---------------------------------------------------------------- receiving

    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        sdi_pkg::t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (tx_expect_q.size() == 0) begin
                $display("%0t: output beat with nothing expected, got %h", $time, o_data);
                errors++;
            end else begin
                want = tx_expect_q.pop_front();
                if (o_data.tx_byte !== want.tx_byte) begin
                    $display("%0t: tx_byte expected %h got %h",
                             $time, want.tx_byte, o_data.tx_byte);
                    errors++;
                end
                if (o_data.select_gap !== want.select_gap) begin
                    $display("%0t: select_gap expected %b got %b",
                             $time, want.select_gap, o_data.select_gap);
                    errors++;
                end
                if (o_data.finished !== want.finished) begin
                    $display("%0t: finished expected %b got %b",
                             $time, want.finished, o_data.finished);
                    errors++;
                end
                if (o_data.status !== want.status) begin
                    $display("%0t: status expected %0d got %0d",
                             $time, want.status, o_data.status);
                    errors++;
                end
                if (o_data.high_capacity !== want.high_capacity) begin
                    $display("%0t: high_capacity expected %b got %b",
                             $time, want.high_capacity, o_data.high_capacity);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if (run_active) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    initial begin
        t_dir_row      dir_tab [$];
        sdi_pkg::t_out idle_out;
        sdi_pkg::t_out gap_out;
        sdi_pkg::t_in  it;
        t_card         c;
        int            ph;
        int            start_beats;
        logic [7:0]    tmo_set  [4];
        int            send_set [4];
        int            stall_set[4];

        tmo_set   = '{8'd255, 8'd1, 8'd2, 8'd100};
        send_set  = '{0, 62, 0, 36};
        stall_set = '{0, 0, 62, 36};

        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_data       = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = 8'd0;
        beats_sent   = 0;
        idle_pct     = 0;
        stall_pct    = 0;
        hold_req     = 0;
        run_active   = 1'b0;

        seq_phase = sdi_pkg::PH_IDLE;
        seq_stage = sdi_pkg::ST_PRE;
        seq_cnt   = 0;
        seq_retry = 8'd0;
        seq_poll  = 0;
        seq_cap   = 1'b0;
        seq_code  = sdi_pkg::STS_OK;
        seq_tmo   = sdi_pkg::CMD_TIMEOUT_RST;
        foreach (seq_resp[k]) seq_resp[k] = 8'h00;

        // directed table: idle beats, start, first cmd0 frame, poll, restart
        idle_out = '0;
        idle_out.tx_byte = 8'hFF;
        gap_out = idle_out;
        gap_out.select_gap = 1'b1;
        dir_tab.push_back('{1'b1, 8'h00, 1'b1, idle_out});
        dir_tab.push_back('{1'b1, 8'hFF, 1'b1, idle_out});
        dir_tab.push_back('{1'b0, 8'h00, 1'b1, gap_out});
        dir_tab.push_back('{1'b1, 8'hFF, 1'b0, '0});
        dir_tab.push_back('{1'b1, 8'h7F, 1'b0, '0});
        dir_tab.push_back('{1'b1, 8'h80, 1'b0, '0});
        dir_tab.push_back('{1'b1, 8'hFF, 1'b1,
                            '{8'h40, 1'b0, 1'b0, sdi_pkg::STS_OK, 1'b0}});
        repeat (4) dir_tab.push_back('{1'b1, 8'h00, 1'b0, '0});
        dir_tab.push_back('{1'b1, 8'hFF, 1'b1,
                            '{8'h95, 1'b0, 1'b0, sdi_pkg::STS_OK, 1'b0}});
        dir_tab.push_back('{1'b1, 8'h80, 1'b0, '0});
        dir_tab.push_back('{1'b1, 8'hFE, 1'b0, '0});
        dir_tab.push_back('{1'b1, 8'h01, 1'b1, gap_out});
        dir_tab.push_back('{1'b1, 8'h55, 1'b0, '0});
        dir_tab.push_back('{1'b0, 8'hAA, 1'b1, gap_out});

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n    <= 1'b1;
        run_active <= 1'b1;
        @(negedge i_clk);

        foreach (dir_tab[k]) begin
            it.mode    = dir_tab[k].mode;
            it.rx_byte = dir_tab[k].rx;
            send_beat(it, dir_tab[k].typed, dir_tab[k].want);
        end

        for (ph = 0; ph < 4; ph++) begin
            drain();
            write_timeout(tmo_set[ph]);
            idle_pct  = send_set[ph];
            stall_pct = stall_set[ph];
            // receiver holds off while beats keep coming, so input stall shows
            if (ph == 0) hold_req++;
            // one full bring-up to the end, through the long acmd41 wait
            if (ph == 3) run_card(CARD_FAST, 900);
            start_beats = beats_sent;
            while (beats_sent - start_beats < PHASE_BEATS) begin
                case ($urandom_range(11))
                    0:       c = CARD_OLD;
                    1:       c = CARD_ECHO;
                    2:       c = CARD_VOLT;
                    3:       c = CARD_STUCK;
                    4:       c = CARD_NOISE;
                    5:       c = CARD_SILENT;
                    default: c = CARD_GOOD;
                endcase
                run_card(c, PHASE_BEATS - (beats_sent - start_beats));
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

endmodule
